### hw/rtl/cwcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwcg_pkg
// Constants, types and the quarter-wave cosine table of the window generator.
// ----------------------------------------------------------------------------
package cwcg_pkg;

    localparam int MAX_POINTS = 8192;
    localparam int COS_DEPTH  = 1024;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int LEN_W   = IDX_W + 1;
    localparam int DIV_W   = IDX_W;
    localparam int PH_W    = 16;
    localparam int NUM_W   = IDX_W + PH_W;
    localparam int DIV_STEPS       = NUM_W;
    localparam int STEPS_PER_STAGE = 8;
    localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    localparam int CA_W  = $clog2(COS_DEPTH) + 2;
    localparam int CR_W  = $clog2(COS_DEPTH);
    localparam int TI_W  = $clog2(COS_DEPTH + 1);
    localparam int CV_W  = 19;
    localparam int CS_W  = CV_W + 1;
    localparam int CF_W  = 18;
    localparam int PR_W  = CF_W + CS_W + 1;
    localparam int TM_W  = CS_W;
    localparam int SUM_W = 21;
    localparam int Q15_W = SUM_W - 3;
    localparam int NTERM = 4;

    localparam logic       REG_LENGTH = 1'b0;
    localparam logic       REG_TYPE   = 1'b1;
    localparam logic [1:0] WIN_RECT    = 2'd0;
    localparam logic [1:0] WIN_HANN    = 2'd1;
    localparam logic [1:0] WIN_HAMMING = 2'd2;
    localparam logic [1:0] WIN_FLATTOP = 2'd3;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_POINTS);

    localparam logic signed [SUM_W-1:0] SUM_ONE    = SUM_W'(262144);
    localparam logic signed [SUM_W-1:0] HANN_A0    = SUM_W'(131072);
    localparam logic signed [SUM_W-1:0] HAMMING_A0 = SUM_W'(142470);
    localparam logic signed [SUM_W-1:0] FLAT_A0    = SUM_W'(56513);
    localparam logic signed [CF_W:0]    HANN_A1    = (CF_W+1)'(131072);
    localparam logic signed [CF_W:0]    HAMMING_A1 = (CF_W+1)'(119674);
    localparam logic signed [CF_W:0]    FLAT_A1    = (CF_W+1)'(109217);
    localparam logic signed [CF_W:0]    FLAT_A2    = (CF_W+1)'(72683);
    localparam logic signed [CF_W:0]    FLAT_A3    = (CF_W+1)'(21910);
    localparam logic signed [CF_W:0]    FLAT_A4    = (CF_W+1)'(1821);
    localparam logic signed [PR_W-1:0]  RND_HALF   = PR_W'(131072);

    localparam logic signed [Q15_W-1:0] Q15_MAX = Q15_W'(32767);
    localparam logic signed [Q15_W-1:0] Q15_MIN = -Q15_W'(32768);

    typedef logic [CV_W-1:0] cos_tab_t [0:COS_DEPTH];

    // cos(pi/2 * k / depth) in Q18 from a Q30 Taylor series
    function automatic cos_tab_t build_cos_table();
        cos_tab_t          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   p;
        longint unsigned   pr;
        longint            t;
        for (int k = 0; k <= COS_DEPTH; k++)
        begin
            x  = (longint'(k) * 64'd1686629713) >> $clog2(COS_DEPTH);
            x2 = (x * x) >> 30;
            t  = 64'd1073741824;
            for (int i = 0; i < 7; i++)
            begin
                pr = (x2 * longint'(t)) >> 30;
                case (i)
                    0: p = pr / 64'd182;
                    1: p = pr / 64'd132;
                    2: p = pr / 64'd90;
                    3: p = pr / 64'd56;
                    4: p = pr / 64'd30;
                    5: p = pr / 64'd12;
                    default: p = pr >> 1;
                endcase
                t = 64'sd1073741824 - longint'(p);
                if (t < 0)
                begin
                    t = 0;
                end
            end
            tab[k] = CV_W'((longint'(t) + 2048) >>> 12);
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TABLE = build_cos_table();

endpackage

### hw/rtl/cosine_window_coefficient_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_window_coefficient_gen
// Stages: divider input, divider, table address, table read, multiply, output.
// Throughput: one item per cycle; a stalled output freezes the whole pipe.
// The phase divider (4 stages, up to 8 quotient bits each) sets the depth.
// Reset: rst_n clears the pipe valids; length resets to 8192, type to rectangle.
// ----------------------------------------------------------------------------
// cosine_window_coefficient_gen
// FFT window weight (rectangle, Hann, Hamming, flat-top) in saturated Q15.
// ----------------------------------------------------------------------------
module cosine_window_coefficient_gen (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [cwcg_pkg::LEN_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cwcg_pkg::IDX_W-1:0]    sample_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [15:0]            coefficient,
    output logic                          clamped
);
    import cwcg_pkg::*;

    logic [LEN_W-1:0] len_reg;
    logic [1:0]       type_reg;
    logic             ce;
    logic [DIV_W-1:0] div_d;

    assign ce       = !(out_valid && out_stall);
    assign in_stall = !ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_RESET;
            type_reg <= WIN_RECT;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_addr == REG_LENGTH)
            begin
                len_reg <= cfg_data;
            end
            else
            begin
                type_reg <= cfg_data[1:0];
            end
        end
    end

    always_comb
    begin
        if (len_reg < LEN_W'(2))
        begin
            div_d = DIV_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_POINTS))
        begin
            div_d = DIV_W'(MAX_POINTS - 1);
        end
        else
        begin
            div_d = DIV_W'(len_reg - LEN_W'(1));
        end
    end

    // divider pipe, index 0 is the input register
    logic             dv_v_reg   [0:DIV_STAGES];
    logic [NUM_W-1:0] dv_num_reg [0:DIV_STAGES];
    logic [DIV_W-1:0] dv_d_reg   [0:DIV_STAGES];
    logic [DIV_W-1:0] dv_rem_reg [0:DIV_STAGES];
    logic [PH_W-1:0]  dv_q_reg   [0:DIV_STAGES];
    logic [1:0]       dv_typ_reg [0:DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            dv_v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dv_num_reg[0] <= {sample_index, PH_W'(0)};
            dv_d_reg[0]   <= div_d;
            dv_rem_reg[0] <= '0;
            dv_q_reg[0]   <= '0;
            dv_typ_reg[0] <= type_reg;
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        logic [NUM_W-1:0] num_next;
        logic [DIV_W-1:0] rem_next;
        logic [PH_W-1:0]  q_next;

        always_comb
        begin
            logic [DIV_W:0] t;
            num_next = dv_num_reg[s];
            rem_next = dv_rem_reg[s];
            q_next   = dv_q_reg[s];
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                if (s * STEPS_PER_STAGE + j < DIV_STEPS)
                begin
                    t        = {rem_next, num_next[NUM_W-1]};
                    num_next = {num_next[NUM_W-2:0], 1'b0};
                    if (t >= {1'b0, dv_d_reg[s]})
                    begin
                        rem_next = DIV_W'(t - {1'b0, dv_d_reg[s]});
                        q_next   = {q_next[PH_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = t[DIV_W-1:0];
                        q_next   = {q_next[PH_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[s+1] <= 1'b0;
            end
            else if (ce)
            begin
                dv_v_reg[s+1] <= dv_v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                dv_num_reg[s+1] <= num_next;
                dv_d_reg[s+1]   <= dv_d_reg[s];
                dv_rem_reg[s+1] <= rem_next;
                dv_q_reg[s+1]   <= q_next;
                dv_typ_reg[s+1] <= dv_typ_reg[s];
            end
        end
    end

    // table address stage
    logic [PH_W-1:0] ph [0:NTERM-1];
    logic            ta_v_reg;
    logic [1:0]      ta_typ_reg;
    logic [TI_W-1:0] ta_idx_reg [0:NTERM-1];
    logic            ta_neg_reg [0:NTERM-1];

    always_comb
    begin
        ph[0] = dv_q_reg[DIV_STAGES];
        ph[1] = {ph[0][PH_W-2:0], 1'b0};
        ph[2] = ph[0] + ph[1];
        ph[3] = {ph[0][PH_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ta_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            ta_v_reg <= dv_v_reg[DIV_STAGES];
        end
    end

    for (genvar h = 0; h < NTERM; h++)
    begin : g_addr
        logic [CA_W-1:0] a;
        logic [CR_W-1:0] r;
        assign a = ph[h][PH_W-1 -: CA_W];
        assign r = a[CR_W-1:0];

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                ta_idx_reg[h] <= (a[CR_W] == 1'b0) ? TI_W'(r)
                                               : TI_W'(TI_W'(COS_DEPTH) - TI_W'(r));
                ta_neg_reg[h] <= a[CR_W+1] ^ a[CR_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ta_typ_reg <= dv_typ_reg[DIV_STAGES];
        end
    end

    // table read stage
    logic                   cr_v_reg;
    logic [1:0]             cr_typ_reg;
    logic signed [CS_W-1:0] cr_cos_reg [0:NTERM-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            cr_v_reg <= ta_v_reg;
        end
    end

    for (genvar h = 0; h < NTERM; h++)
    begin : g_rd
        logic signed [CS_W-1:0] cv;
        assign cv = $signed({1'b0, COS_TABLE[ta_idx_reg[h]]});

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                cr_cos_reg[h] <= ta_neg_reg[h] ? -cv : cv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cr_typ_reg <= ta_typ_reg;
        end
    end

    // multiply stage
    logic signed [CF_W:0]   coef [0:NTERM-1];
    logic                   mt_v_reg;
    logic [1:0]             mt_typ_reg;
    logic signed [TM_W-1:0] mt_term_reg [0:NTERM-1];

    always_comb
    begin
        case (cr_typ_reg)
            WIN_HANN:    coef[0] = HANN_A1;
            WIN_HAMMING: coef[0] = HAMMING_A1;
            default:     coef[0] = FLAT_A1;
        endcase
        coef[1] = FLAT_A2;
        coef[2] = FLAT_A3;
        coef[3] = FLAT_A4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mt_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            mt_v_reg <= cr_v_reg;
        end
    end

    for (genvar h = 0; h < NTERM; h++)
    begin : g_mul
        logic signed [PR_W-1:0] prod;
        logic signed [PR_W-1:0] rnd;
        assign prod = PR_W'(coef[h]) * PR_W'(cr_cos_reg[h]);
        assign rnd  = (prod + RND_HALF) >>> 18;

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                mt_term_reg[h] <= rnd[TM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mt_typ_reg <= cr_typ_reg;
        end
    end

    // sum, scale, clamp
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] t1;
    logic signed [SUM_W-1:0] t2;
    logic signed [SUM_W-1:0] t3;
    logic signed [SUM_W-1:0] t4;
    logic signed [Q15_W-1:0] q15;
    logic signed [15:0]      coef_next;
    logic                    clamp_next;

    assign t1 = SUM_W'(mt_term_reg[0]);
    assign t2 = SUM_W'(mt_term_reg[1]);
    assign t3 = SUM_W'(mt_term_reg[2]);
    assign t4 = SUM_W'(mt_term_reg[3]);

    always_comb
    begin
        case (mt_typ_reg)
            WIN_RECT:    sum = SUM_ONE;
            WIN_HANN:    sum = HANN_A0 - t1;
            WIN_HAMMING: sum = HAMMING_A0 - t1;
            default:     sum = FLAT_A0 - t1 + t2 - t3 + t4;
        endcase
        if (sum < 0)
        begin
            q15 = Q15_W'((sum + SUM_W'(7)) >>> 3);
        end
        else
        begin
            q15 = Q15_W'(sum >>> 3);
        end
        if (q15 > Q15_MAX)
        begin
            coef_next  = 16'sh7fff;
            clamp_next = 1'b1;
        end
        else if (q15 < Q15_MIN)
        begin
            coef_next  = -16'sh8000;
            clamp_next = 1'b1;
        end
        else
        begin
            coef_next  = q15[15:0];
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (ce)
        begin
            out_valid <= mt_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            coefficient <= coef_next;
            clamped     <= clamp_next;
        end
    end

endmodule

### hw/rtl/cwcg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwcg_checker
// Port-level checks of the window coefficient generator.
// ----------------------------------------------------------------------------
module cwcg_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [15:0]            coefficient,
    input  logic                          clamped
);
    import cwcg_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(coefficient) && $stable(clamped))
        else $error("stalled item changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("stalled input item dropped");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |-> coefficient == 16'sh7fff || coefficient == -16'sh8000)
        else $error("clamp flag without rail value");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("item out of reset");

endmodule

bind cosine_window_coefficient_gen cwcg_checker u_cwcg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .coefficient (coefficient),
    .clamped     (clamped)
);
